[rtl/cps_pkg.sv]
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants for circle pair separation
// Field widths, pipeline sizes and the context carried along the pipeline.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int CoordW = 32;   // signed Q16.16 coordinate
  localparam int RadW   = 24;   // unsigned Q8.16 radius
  localparam int RrW    = 25;   // summed radius, also bounds |dx|, |dz|, d
  localparam int SqW    = 2 * RrW;       // squared distance
  localparam int RootW  = RrW;           // floor square root
  localparam int RemW   = RootW + 1;     // square root remainder
  localparam int DenW   = RootW + 1;     // divisor 2*d
  localparam int QuoW   = RrW - 1;       // push magnitude, at most overlap/2
  localparam int PushW  = CoordW + 2;    // coordinate plus push before clamping

  localparam int FrontStages = 3;
  localparam int SqrtStages  = RootW;
  localparam int DivStages   = QuoW + 2;

  localparam logic signed [PushW-1:0] SatMax = PushW'(64'sd2147483647);
  localparam logic signed [PushW-1:0] SatMin = -PushW'(64'sd2147483648);

  // Context that travels with each pair through every stage.
  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] bz;
    logic                     sx;   // dx negative
    logic                     sz;   // dz negative
    logic [RrW-1:0]           adx;
    logic [RrW-1:0]           adz;
    logic [RrW-1:0]           rr;
    logic                     hit;  // near, later: pushed apart
  } ctx_t;

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [PushW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > SatMax) begin
      r = SatMax[CoordW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[CoordW-1:0];
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/cps_if.sv]
// ----------------------------------------------------------------------------
// cps_if: valid/ready channels for circle pair separation
// Input pair channel and result channel.
// ----------------------------------------------------------------------------
interface cps_in_if;
  import cps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] first_x;
  logic signed [CoordW-1:0] first_z;
  logic [RadW-1:0]          first_radius;
  logic signed [CoordW-1:0] second_x;
  logic signed [CoordW-1:0] second_z;
  logic [RadW-1:0]          second_radius;

  modport source (output valid, first_x, first_z, first_radius, second_x, second_z,
                  second_radius, input ready);
  modport sink (input valid, first_x, first_z, first_radius, second_x, second_z,
                second_radius, output ready);
endinterface

interface cps_out_if;
  import cps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] moved_first_x;
  logic signed [CoordW-1:0] moved_first_z;
  logic signed [CoordW-1:0] moved_second_x;
  logic signed [CoordW-1:0] moved_second_z;
  logic                     overlapped;

  modport source (output valid, moved_first_x, moved_first_z, moved_second_x,
                  moved_second_z, overlapped, input ready);
  modport sink (input valid, moved_first_x, moved_first_z, moved_second_x,
                moved_second_z, overlapped, output ready);
endinterface

[rtl/circle_pair_separation.sv]
// Pipeline: 3 front, 25 root and 26 divide stages, then 1 output register;
//   a stall on the result side holds every stage that cannot move on.
// Throughput: one pair per cycle unless the result stalls; root and divider
//   settle one bit per root or quotient stage, so neither limits the rate.
// Reset: rst_ni clears every stage valid bit at once; data registers keep
//   whatever they hold and are ignored until refilled.
// ----------------------------------------------------------------------------
// circle_pair_separation: push two overlapping circles apart
// Streams circle pairs and returns centers moved by half the overlap each.
// ----------------------------------------------------------------------------
module circle_pair_separation (
  input  logic       clk_i,
  input  logic       rst_ni,
  cps_in_if.sink     pair_i,
  cps_out_if.source  result_o
);
  import cps_pkg::*;

  // front -> root
  logic            f_valid, f_ready;
  ctx_t            f_ctx;
  logic [SqW-1:0]  f_d2;
  // root -> divide
  logic             s_valid, s_ready;
  ctx_t             s_ctx;
  logic [RootW-1:0] s_root;
  // divide -> output register
  logic            d_valid, d_ready;
  ctx_t            d_ctx;
  logic [QuoW-1:0] d_qx, d_qz;

  // output register
  logic                     out_v_q;
  logic signed [CoordW-1:0] fx_q, fz_q, sx_q, sz_q;
  logic                     hit_q;
  logic signed [PushW-1:0]  px, pz;
  logic signed [CoordW-1:0] fx_d, fz_d, sx_d, sz_d;

  // Stage 1-3: deltas, range check, squares, overlap compare.
  cps_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (pair_i.valid),
    .in_ready_o      (pair_i.ready),
    .first_x_i       (pair_i.first_x),
    .first_z_i       (pair_i.first_z),
    .first_radius_i  (pair_i.first_radius),
    .second_x_i      (pair_i.second_x),
    .second_z_i      (pair_i.second_z),
    .second_radius_i (pair_i.second_radius),
    .out_valid_o     (f_valid),
    .out_ready_i     (f_ready),
    .out_ctx_o       (f_ctx),
    .out_d2_o        (f_d2)
  );

  // Floor square root of the squared distance; zero radicand on a miss.
  cps_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_ctx_i    (f_ctx),
    .in_d2_i     (f_d2),
    .out_valid_o (s_valid),
    .out_ready_i (s_ready),
    .out_ctx_o   (s_ctx),
    .out_root_o  (s_root)
  );

  // Per-axis push magnitude; the quotient is garbage on a miss and dropped.
  cps_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_valid),
    .in_ready_o  (s_ready),
    .in_ctx_i    (s_ctx),
    .in_root_i   (s_root),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .out_ctx_o   (d_ctx),
    .out_qx_o    (d_qx),
    .out_qz_o    (d_qz)
  );

  // Load a new result whenever the register is empty or being drained.
  assign d_ready = !out_v_q || result_o.ready;

  always_comb begin
    // give each push the sign of its delta
    px = d_ctx.sx ? -PushW'(d_qx) : PushW'(d_qx);
    pz = d_ctx.sz ? -PushW'(d_qz) : PushW'(d_qz);
    if (d_ctx.hit) begin
      // first circle moves against the delta, second along it
      fx_d = sat_coord(PushW'(d_ctx.ax) - px);
      fz_d = sat_coord(PushW'(d_ctx.az) - pz);
      sx_d = sat_coord(PushW'(d_ctx.bx) + px);
      sz_d = sat_coord(PushW'(d_ctx.bz) + pz);
    end else begin
      // pass positions through unchanged
      fx_d = d_ctx.ax;
      fz_d = d_ctx.az;
      sx_d = d_ctx.bx;
      sz_d = d_ctx.bz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (d_ready) begin
      out_v_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready) begin
      fx_q  <= fx_d;
      fz_q  <= fz_d;
      sx_q  <= sx_d;
      sz_q  <= sz_d;
      hit_q <= d_ctx.hit;
    end
  end

  assign result_o.valid          = out_v_q;
  assign result_o.moved_first_x  = fx_q;
  assign result_o.moved_first_z  = fz_q;
  assign result_o.moved_second_x = sx_q;
  assign result_o.moved_second_z = sz_q;
  assign result_o.overlapped     = hit_q;

endmodule

[rtl/cps_front.sv]
// ----------------------------------------------------------------------------
// cps_front: deltas, squares and overlap test
// Three stages: delta and range check, squares, squared-distance compare.
// ----------------------------------------------------------------------------
module cps_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [cps_pkg::CoordW-1:0] first_x_i,
  input  logic signed [cps_pkg::CoordW-1:0] first_z_i,
  input  logic [cps_pkg::RadW-1:0]          first_radius_i,
  input  logic signed [cps_pkg::CoordW-1:0] second_x_i,
  input  logic signed [cps_pkg::CoordW-1:0] second_z_i,
  input  logic [cps_pkg::RadW-1:0]          second_radius_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output cps_pkg::ctx_t                     out_ctx_o,
  output logic [cps_pkg::SqW-1:0]           out_d2_o
);
  import cps_pkg::*;

  logic [FrontStages-1:0] v_q;
  logic [FrontStages-1:0] adv;

  logic signed [CoordW:0] dx, dz;
  logic [CoordW:0]        adx_w, adz_w;
  logic [RrW-1:0]         rr_w;
  ctx_t                   ctx0_d, ctx0_q, ctx1_q, ctx2_d, ctx2_q;
  logic [SqW-1:0]         sqx_d, sqz_d, rr2_d, sqx_q, sqz_q, rr2_q;
  logic [SqW:0]           sum;
  logic [SqW-1:0]         d2_d, d2_q;

  // a stage may load when it is empty or its content moves on
  assign adv[2]     = !v_q[2] || out_ready_i;
  assign adv[1]     = !v_q[1] || adv[2];
  assign adv[0]     = !v_q[0] || adv[1];
  assign in_ready_o = adv[0];

  always_comb begin
    dx     = {second_x_i[CoordW-1], second_x_i} - {first_x_i[CoordW-1], first_x_i};
    dz     = {second_z_i[CoordW-1], second_z_i} - {first_z_i[CoordW-1], first_z_i};
    adx_w  = dx[CoordW] ? (CoordW+1)'(-dx) : (CoordW+1)'(dx);
    adz_w  = dz[CoordW] ? (CoordW+1)'(-dz) : (CoordW+1)'(dz);
    rr_w   = {1'b0, first_radius_i} + {1'b0, second_radius_i};
    ctx0_d.ax  = first_x_i;
    ctx0_d.az  = first_z_i;
    ctx0_d.bx  = second_x_i;
    ctx0_d.bz  = second_z_i;
    ctx0_d.sx  = dx[CoordW];
    ctx0_d.sz  = dz[CoordW];
    ctx0_d.adx = adx_w[RrW-1:0];
    ctx0_d.adz = adz_w[RrW-1:0];
    ctx0_d.rr  = rr_w;
    ctx0_d.hit = (adx_w < (CoordW+1)'(rr_w)) && (adz_w < (CoordW+1)'(rr_w));
  end

  assign sqx_d = ctx0_q.adx * ctx0_q.adx;
  assign sqz_d = ctx0_q.adz * ctx0_q.adz;
  assign rr2_d = ctx0_q.rr * ctx0_q.rr;

  always_comb begin
    sum        = {1'b0, sqx_q} + {1'b0, sqz_q};
    ctx2_d     = ctx1_q;
    ctx2_d.hit = ctx1_q.hit && (sum != '0) && (sum < {1'b0, rr2_q});
    d2_d       = ctx2_d.hit ? sum[SqW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) ctx0_q <= ctx0_d;
    if (adv[1]) begin
      ctx1_q <= ctx0_q;
      sqx_q  <= sqx_d;
      sqz_q  <= sqz_d;
      rr2_q  <= rr2_d;
    end
    if (adv[2]) begin
      ctx2_q <= ctx2_d;
      d2_q   <= d2_d;
    end
  end

  assign out_valid_o = v_q[2];
  assign out_ctx_o   = ctx2_q;
  assign out_d2_o    = d2_q;

endmodule

[rtl/cps_sqrt.sv]
// ----------------------------------------------------------------------------
// cps_sqrt: pipelined floor square root
// One result bit per stage, digit by digit, remainder carried forward.
// ----------------------------------------------------------------------------
module cps_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cps_pkg::ctx_t              in_ctx_i,
  input  logic [cps_pkg::SqW-1:0]    in_d2_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cps_pkg::ctx_t              out_ctx_o,
  output logic [cps_pkg::RootW-1:0]  out_root_o
);
  import cps_pkg::*;

  logic [SqrtStages-1:0] v_q;
  logic [SqrtStages-1:0] adv;
  ctx_t                  ctx_q  [SqrtStages];
  logic [SqW-1:0]        rad_q  [SqrtStages];
  logic [RemW-1:0]       rem_q  [SqrtStages];
  logic [RootW-1:0]      root_q [SqrtStages];

  assign in_ready_o  = adv[0];

  for (genvar k = 0; k < SqrtStages; k++) begin : g_st
    localparam int I = SqrtStages - 1 - k;
    logic             v_in;
    ctx_t             ctx_in;
    logic [SqW-1:0]   rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RemW+1:0]  rem_sh, trial;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign ctx_in  = in_ctx_i;
      assign rad_in  = in_d2_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign ctx_in  = ctx_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    if (k == SqrtStages - 1) begin : g_last
      assign adv[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid
      assign adv[k] = !v_q[k] || adv[k+1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_in, rad_in[2*I+1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        ctx_q[k] <= ctx_in;
        rad_q[k] <= rad_in;
        if (rem_sh >= trial) begin
          rem_q[k]  <= RemW'(rem_sh - trial);
          root_q[k] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= RemW'(rem_sh);
          root_q[k] <= {root_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid_o = v_q[SqrtStages-1];
  assign out_ctx_o   = ctx_q[SqrtStages-1];
  assign out_root_o  = root_q[SqrtStages-1];

endmodule

[rtl/cps_div.sv]
// ----------------------------------------------------------------------------
// cps_div: push magnitudes |delta|*overlap / (2*d) for both axes
// Overlap and divisor, products, then one quotient bit per stage per lane.
// ----------------------------------------------------------------------------
module cps_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  cps_pkg::ctx_t             in_ctx_i,
  input  logic [cps_pkg::RootW-1:0] in_root_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cps_pkg::ctx_t             out_ctx_o,
  output logic [cps_pkg::QuoW-1:0]  out_qx_o,
  output logic [cps_pkg::QuoW-1:0]  out_qz_o
);
  import cps_pkg::*;

  logic [DivStages-1:0] v_q;
  logic [DivStages-1:0] adv;

  ctx_t            ctx0_q, ctx1_q;
  logic [RrW-1:0]  ovl_q;
  logic [DenW-1:0] den0_q, den1_q;
  logic [SqW-1:0]  num1_q [2];

  ctx_t            ctx_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [SqW-1:0]  num_q [QuoW][2];
  logic [DenW-1:0] rem_q [QuoW][2];
  logic [QuoW-1:0] quo_q [QuoW][2];

  for (genvar s = 0; s < DivStages; s++) begin : g_adv
    if (s == DivStages - 1) begin : g_last
      assign adv[s] = !v_q[s] || out_ready_i;
    end else begin : g_mid
      assign adv[s] = !v_q[s] || adv[s+1];
    end
  end
  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < DivStages; s++) begin
        if (adv[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ctx0_q <= in_ctx_i;
      ovl_q  <= in_ctx_i.rr - in_root_i;
      den0_q <= {in_root_i, 1'b0};
    end
    if (adv[1]) begin
      ctx1_q    <= ctx0_q;
      den1_q    <= den0_q;
      num1_q[0] <= ctx0_q.adx * ovl_q;
      num1_q[1] <= ctx0_q.adz * ovl_q;
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_st
    localparam int I = QuoW - 1 - k;
    ctx_t            ctx_in;
    logic [DenW-1:0] den_in;

    if (k == 0) begin : g_first
      assign ctx_in = ctx1_q;
      assign den_in = den1_q;
    end else begin : g_next
      assign ctx_in = ctx_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv[k+2]) begin
        ctx_q[k] <= ctx_in;
        den_q[k] <= den_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [SqW-1:0]  num_in;
      logic [DenW-1:0] rem_in;
      logic [QuoW-1:0] quo_in;
      logic [DenW:0]   rem_sh;

      if (k == 0) begin : g_first
        // quotient fits QuoW bits, so the top dividend bits are below 2*d
        assign num_in = num1_q[l];
        assign rem_in = num1_q[l][SqW-1 -: DenW];
        assign quo_in = '0;
      end else begin : g_next
        assign num_in = num_q[k-1][l];
        assign rem_in = rem_q[k-1][l];
        assign quo_in = quo_q[k-1][l];
      end

      assign rem_sh = {rem_in, num_in[I]};

      always_ff @(posedge clk_i) begin
        if (adv[k+2]) begin
          num_q[k][l] <= num_in;
          if (rem_sh >= {1'b0, den_in}) begin
            rem_q[k][l] <= DenW'(rem_sh - {1'b0, den_in});
            quo_q[k][l] <= {quo_in[QuoW-2:0], 1'b1};
          end else begin
            rem_q[k][l] <= DenW'(rem_sh);
            quo_q[k][l] <= {quo_in[QuoW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid_o = v_q[DivStages-1];
  assign out_ctx_o   = ctx_q[QuoW-1];
  assign out_qx_o    = quo_q[QuoW-1][0];
  assign out_qz_o    = quo_q[QuoW-1][1];

endmodule

[rtl/cps_checker.sv]
// ----------------------------------------------------------------------------
// cps_checker: port-level checks for circle pair separation
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module cps_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [cps_pkg::CoordW-1:0] moved_first_x_i,
  input logic signed [cps_pkg::CoordW-1:0] moved_first_z_i,
  input logic signed [cps_pkg::CoordW-1:0] moved_second_x_i,
  input logic signed [cps_pkg::CoordW-1:0] moved_second_z_i,
  input logic                              overlapped_i
);
  import cps_pkg::*;

  // A stalled transaction holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(moved_first_x_i)
      && $stable(moved_first_z_i) && $stable(moved_second_x_i)
      && $stable(moved_second_z_i) && $stable(overlapped_i))
    else $error("result changed while stalled");

  // Pushed circles never end up at the same center.
  a_pushed_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overlapped_i |->
      (moved_first_x_i != moved_second_x_i) || (moved_first_z_i != moved_second_z_i))
    else $error("pushed circles share a center");

  // No transaction is offered once reset has been applied.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind circle_pair_separation cps_checker u_cps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .moved_first_x_i  (result_o.moved_first_x),
  .moved_first_z_i  (result_o.moved_first_z),
  .moved_second_x_i (result_o.moved_second_x),
  .moved_second_z_i (result_o.moved_second_z),
  .overlapped_i     (result_o.overlapped)
);

[verif/tb_cps_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cps_channels: payload records for the circle pair channels
// Holds one circle pair and one separation result as packed structs.
// ----------------------------------------------------------------------------
package tb_cps_types_pkg;
  import cps_pkg::*;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] az;
    logic [RadW-1:0]          ra;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] bz;
    logic [RadW-1:0]          rb;
  } pair_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] bz;
    logic                     hit;
  } moved_t;
endpackage

[verif/tb_circle_pair_separation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_pair_separation: streaming check of circle pair separation
// Feeds directed and random circle pairs with random gaps on both channels,
// predicts each moved pair in the bench and compares results in order.
// ----------------------------------------------------------------------------
module tb_circle_pair_separation;
  import cps_pkg::*;
  import tb_cps_types_pkg::*;

  localparam int PipeLatency = 55;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cps_in_if  pair_ch ();
  cps_out_if result_ch ();

  circle_pair_separation dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pair_i   (pair_ch.sink),
    .result_o (result_ch.source)
  );

  always #2 clk_i = ~clk_i;

  pair_t  pending_pairs[$];
  moved_t expected_moves[$];
  int     mismatch_count = 0;
  bit     stimulus_done = 1'b0;
  bit     drain_hold = 1'b0;    // sender holds off until the pipeline drains
  bit     pair_taken = 1'b0;    // a pair was accepted at the last rising edge
  int     send_gap = 0;
  int     recv_gap = 0;

  // Floor square root, one result bit at a time from the top.
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic longint clamp32(input longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end
    return r;
  endfunction

  // Push one pair apart: half the overlap each, along the center line.
  function automatic moved_t separate_pair(input pair_t p);
    moved_t m;
    longint ax, az, bx, bz, dx, dz, px, pz;
    longint unsigned rr, adx, adz, d2, d, ovl;
    ax = p.ax; az = p.az; bx = p.bx; bz = p.bz;
    dx = bx - ax;
    dz = bz - az;
    rr = longint'(p.ra) + longint'(p.rb);
    adx = dx < 0 ? -dx : dx;
    adz = dz < 0 ? -dz : dz;
    m = '{ax: p.ax, az: p.az, bx: p.bx, bz: p.bz, hit: 1'b0};
    if (adx < rr && adz < rr) begin
      d2 = adx * adx + adz * adz;
      if (d2 != 0 && d2 < rr * rr) begin
        d = isqrt(d2);
        ovl = rr - d;
        px = longint'((adx * ovl) / (2 * d));
        pz = longint'((adz * ovl) / (2 * d));
        if (dx < 0) px = -px;
        if (dz < 0) pz = -pz;
        m.ax = 32'(clamp32(ax - px));
        m.az = 32'(clamp32(az - pz));
        m.bx = 32'(clamp32(bx + px));
        m.bz = 32'(clamp32(bz + pz));
        m.hit = 1'b1;
      end
    end
    return m;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int g;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: g = 0;
      9:          g = $urandom_range(10, 40);
      default:    g = $urandom_range(1, 3);
    endcase
    return g;
  endfunction

  function automatic logic signed [31:0] near_coord(input logic signed [31:0] c, int span);
    longint v;
    v = longint'(c) + $signed($urandom_range(0, 2 * span)) - span;
    return 32'(clamp32(v));
  endfunction

  function automatic logic signed [31:0] rand_coord();
    logic signed [31:0] c;
    case ($urandom_range(0, 5))
      0:       c = 32'sh7fff_ffff - $urandom_range(0, 1 << 20);
      1:       c = 32'sh8000_0000 + $urandom_range(0, 1 << 20);
      default: c = $urandom;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] rand_radius();
    logic [23:0] r;
    case ($urandom_range(0, 7))
      0:       r = 24'(24'hff_ffff - $urandom_range(0, 255));
      1:       r = 24'($urandom_range(0, 3));
      default: r = 24'($urandom);
    endcase
    return r;
  endfunction

  task automatic add_pair(input logic signed [31:0] ax, az, input logic [23:0] ra,
                          input logic signed [31:0] bx, bz, input logic [23:0] rb);
    pending_pairs.push_back('{ax: ax, az: az, ra: ra, bx: bx, bz: bz, rb: rb});
  endtask

  // Fill the pair queue: directed corners first, then random pairs.
  initial begin
    pair_t p;
    int span;
    add_pair(0, 0, 24'h1_0000, 0, 0, 24'h1_0000);                       // coincident centers
    add_pair(0, 0, 24'h0, 1, 1, 24'h0);                                 // zero radii
    add_pair(0, 0, 24'h1_0000, 32'sh2_0000, 0, 24'h1_0000);             // exactly touching
    add_pair(0, 0, 24'h1_0000, 32'sh1_0000, 0, 24'h1_0000);             // overlap on x
    add_pair(0, 0, 24'h1_0000, 0, -32'sh1_0000, 24'h1_0000);            // overlap on -z
    add_pair(0, 0, 24'hff_ffff, 1, 1, 24'hff_ffff);                     // tiny gap, huge radii
    add_pair(0, 0, 24'hff_ffff, 32'sh1ff_fffd, 0, 24'hff_ffff);         // near the radius bound
    add_pair(32'sh7fff_ffff, 32'sh7fff_ffff, 24'hff_ffff,
             32'sh7fff_fff0, 32'sh7fff_fff0, 24'hff_ffff);              // saturate high
    add_pair(32'sh8000_0000, 32'sh8000_0000, 24'hff_ffff,
             32'sh8000_0010, 32'sh8000_0010, 24'hff_ffff);              // saturate low
    add_pair(32'sh8000_0000, 0, 24'hff_ffff, 32'sh7fff_ffff, 0, 24'hff_ffff); // far apart
    add_pair(32'shffff_ffff, 32'sh0, 24'h00_0001, 32'sh0, 32'sh0, 24'h00_0001);
    add_pair(-32'sh5_0000, 32'sh3_0000, 24'h8_0000, 32'sh2_0000, -32'sh1_0000, 24'h4_0000);
    add_pair(32'sh1234_5678, -32'sh1234_5678, 24'h12_3456,
             32'sh1230_0000, -32'sh1238_0000, 24'hab_cdef);
    for (int n = 0; n < 1800; n++) begin
      p.ax = rand_coord();
      p.az = rand_coord();
      p.ra = rand_radius();
      p.rb = rand_radius();
      if ($urandom_range(0, 4) != 0) begin
        // Keep most pairs close enough to overlap.
        span = int'(p.ra) + int'(p.rb) + 1;
        if (span > (1 << 30)) span = 1 << 30;
        p.bx = near_coord(p.ax, span);
        p.bz = near_coord(p.az, span);
      end else begin
        p.bx = rand_coord();
        p.bz = rand_coord();
      end
      pending_pairs.push_back(p);
    end
  end

  // Driver: present pairs at the falling edge, advance on acceptance.
  initial begin
    pair_ch.valid = 1'b0;
    pair_ch.first_x = '0;
    pair_ch.first_z = '0;
    pair_ch.first_radius = '0;
    pair_ch.second_x = '0;
    pair_ch.second_z = '0;
    pair_ch.second_radius = '0;
    result_ch.ready = 1'b0;
  end

  int accepted_pairs = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pair_taken) begin
        accepted_pairs <= accepted_pairs + 1;
      end
      // Hold the current pair until the block takes it.
      if (!pair_ch.valid || pair_taken) begin
        if (accepted_pairs == 900 && !drain_hold && expected_moves.size() != 0) begin
          pair_ch.valid <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          pair_ch.valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          pair_t p;
          p = pending_pairs.pop_front();
          pair_ch.valid <= 1'b1;
          pair_ch.first_x <= p.ax;
          pair_ch.first_z <= p.az;
          pair_ch.first_radius <= p.ra;
          pair_ch.second_x <= p.bx;
          pair_ch.second_z <= p.bz;
          pair_ch.second_radius <= p.rb;
          send_gap <= (accepted_pairs < 300 || accepted_pairs > 1500) ? 0 : pick_gap();
          if (accepted_pairs == 900) drain_hold <= 1'b1;
        end else begin
          pair_ch.valid <= 1'b0;
          stimulus_done <= 1'b1;
        end
      end
      // Receiver stalls at random.
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        recv_gap <= (accepted_pairs > 1200) ? 0 : pick_gap();
      end
    end
  end

  // Monitor: predict on accepted pairs, compare accepted results.
  always @(posedge clk_i) begin
    moved_t want;
    moved_t got;
    if (rst_ni) begin
      pair_taken <= pair_ch.valid && pair_ch.ready;
      if (pair_ch.valid && pair_ch.ready) begin
        expected_moves.push_back(separate_pair('{ax: pair_ch.first_x, az: pair_ch.first_z,
          ra: pair_ch.first_radius, bx: pair_ch.second_x, bz: pair_ch.second_z,
          rb: pair_ch.second_radius}));
      end
      if (result_ch.valid && result_ch.ready) begin
        got = '{ax: result_ch.moved_first_x, az: result_ch.moved_first_z,
                bx: result_ch.moved_second_x, bz: result_ch.moved_second_z,
                hit: result_ch.overlapped};
        if (expected_moves.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_moves.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  // Release reset, then wait for the stream to drain.
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stimulus_done && expected_moves.size() == 0);
    repeat (2 * PipeLatency) @(posedge clk_i);
    if (mismatch_count == 0 && expected_moves.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
rtl/cps_pkg.sv
rtl/cps_if.sv
rtl/cps_front.sv
rtl/cps_sqrt.sv
rtl/cps_div.sv
rtl/circle_pair_separation.sv
rtl/cps_checker.sv
verif/tb_cps_channels.sv
verif/tb_circle_pair_separation.sv
